### rtl/dqpi_pkg.sv
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared widths, register codes and the control program of the dq current
// PI controller.
// ----------------------------------------------------------------------------
package dqpi_pkg;

   // signal and integrator formats
   localparam int SIG_W       = 16;               // Q7.8 currents and voltages
   localparam int INT_FRAC    = 24;               // integrator fraction bits
   localparam int KP_W        = 16;               // Q4.12
   localparam int KI_W        = 20;               // Q16.4 per second
   localparam int DT_W        = 20;               // 2^-24 s units
   localparam int CSR_W       = 20;
   localparam int CSR_IDX_W   = 3;

   localparam int LIM_W       = SIG_W - 1;        // limit magnitude, Q7.8
   localparam int OUT_SHIFT   = INT_FRAC - 8;     // Q7.24 -> Q7.8
   localparam int LIMI_W      = LIM_W + OUT_SHIFT;
   localparam int INT_W       = LIMI_W + 1;       // integrator, signed
   localparam int CAP_W       = LIMI_W + 1;       // twice the limit
   localparam int ACC_W       = INT_W + 3;        // working width of adds
   localparam int KD_W        = KI_W + DT_W;      // ki * dt
   localparam int MUL_B_W     = DT_W;
   localparam int PROD_W      = KD_W + MUL_B_W;
   localparam int KPE_W       = KP_W + SIG_W;
   localparam int INC_SHIFT   = 36 - INT_FRAC;
   localparam int P_SHIFT     = INT_FRAC - 20;
   localparam int RND_W       = PROD_W - INC_SHIFT + 1;

   localparam logic [LIM_W:0]   LIMIT_FLOOR = (LIM_W + 1)'(256);
   localparam logic [LIM_W:0]   SIG_MAX     = (LIM_W + 1)'((1 << (SIG_W - 1)) - 1);

   // register reset values: kp = 0.2, ki = 40.0 per second
   localparam logic [KP_W-1:0] KP_RESET = KP_W'(819);
   localparam logic [KI_W-1:0] KI_RESET = KI_W'(640);
   localparam logic [DT_W-1:0] DT_RESET = DT_W'(1677);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_D_PROP_GAIN   = 3'd0,
      CSR_D_INT_GAIN    = 3'd1,
      CSR_Q_PROP_GAIN   = 3'd2,
      CSR_Q_INT_GAIN    = 3'd3,
      CSR_SAMPLE_PERIOD = 3'd4
   } csr_index_type;

   // program steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_KD    = 3'd0;
   localparam logic [STEP_W-1:0] STEP_KP    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_PROD  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ROUND = 3'd3;
   localparam logic [STEP_W-1:0] STEP_INTEG = 3'd4;
   localparam logic [STEP_W-1:0] STEP_SAT   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_WB    = 3'd6;
   localparam logic [STEP_W-1:0] STEP_ZERO  = 3'd7;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_KD,      // ki * dt
      MUL_KP,      // kp * |err|
      MUL_INC      // kd * |err|
   } mul_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_ZERO_CHK,  // jump to the zero step when the period is zero
      SEQ_AXIS,      // d axis: restart for q; q axis: finish
      SEQ_FINISH
   } seq_type;

   typedef struct packed {
      mul_op_type mul;
      logic       ld_kd;
      logic       ld_p;
      logic       ld_inc;
      logic       ld_acc;
      logic       ld_s;
      logic       wb;
      logic       zero_out;
      seq_type    seq;
   } ucode_type;

   function automatic ucode_type ucode_fetch(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '0;
      unique case (step)
         STEP_KD: begin
            uc.mul = MUL_KD;
            uc.seq = SEQ_ZERO_CHK;
         end
         STEP_KP: begin
            uc.mul   = MUL_KP;
            uc.ld_kd = 1'b1;
         end
         STEP_PROD: begin
            uc.mul  = MUL_INC;
            uc.ld_p = 1'b1;
         end
         STEP_ROUND: uc.ld_inc = 1'b1;
         STEP_INTEG: uc.ld_acc = 1'b1;
         STEP_SAT:   uc.ld_s   = 1'b1;
         STEP_WB: begin
            uc.wb  = 1'b1;
            uc.seq = SEQ_AXIS;
         end
         STEP_ZERO: begin
            uc.zero_out = 1'b1;
            uc.seq      = SEQ_FINISH;
         end
      endcase
      return uc;
   endfunction

endpackage

### rtl/dq_current_pi_controller.sv
// ----------------------------------------------------------------------------
// dq_current_pi_controller
// Two-axis PI current controller with symmetric output limit and
// back-calculation anti-windup, run by a small microprogram on one datapath.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  d/q reference, d/q measured, limit
//  rsp      out        rsp_valid/rsp_ready  d_voltage, q_voltage
//  csr      in         csr_write_en         csr_index, csr_data
//
//  Each item runs 7 program steps per axis on the shared 40x20
//  multiplier; a new transfer is taken only once the item is through.
//  A zero sample period runs only the first and the zero step and leaves the integrators alone.
//  Synchronous reset zeroes the integrators and restores the default gains.
//  The result register frees the input side; the last step holds only while
//  an earlier result still waits on rsp_ready.
//
module dq_current_pi_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [dqpi_pkg::SIG_W-1:0] req_d_reference,
   input  logic signed [dqpi_pkg::SIG_W-1:0] req_d_measured,
   input  logic signed [dqpi_pkg::SIG_W-1:0] req_q_reference,
   input  logic signed [dqpi_pkg::SIG_W-1:0] req_q_measured,
   input  logic signed [dqpi_pkg::SIG_W-1:0] req_voltage_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [dqpi_pkg::SIG_W-1:0] rsp_d_voltage,
   output logic signed [dqpi_pkg::SIG_W-1:0] rsp_q_voltage,
   input  logic                          csr_write_en,
   input  logic [dqpi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dqpi_pkg::CSR_W-1:0]     csr_data
);
   import dqpi_pkg::*;

   // control
   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                axis_ff, axis_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [KP_W-1:0]     kp_ff [2];
   logic [KP_W-1:0]     kp_in [2];
   logic [KI_W-1:0]     ki_ff [2];
   logic [KI_W-1:0]     ki_in [2];
   logic [DT_W-1:0]     dt_ff, dt_in;

   // item and datapath
   logic [LIM_W-1:0]    lim_ff, lim_in;
   logic [SIG_W-1:0]    e_mag_ff [2];
   logic [SIG_W-1:0]    e_mag_in [2];
   logic                e_neg_ff [2];
   logic                e_neg_in [2];
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [KD_W-1:0]     kd_ff, kd_in;
   logic signed [ACC_W-1:0] p_ff, p_in;
   logic signed [ACC_W-1:0] inc_ff, inc_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] s_ff, s_in;
   logic                sat_ff, sat_in;
   logic signed [INT_W-1:0] integ_ff [2];
   logic signed [INT_W-1:0] integ_in [2];
   logic signed [SIG_W-1:0] vd_ff, vd_in;
   logic signed [SIG_W-1:0] rsp_d_ff, rsp_d_in;
   logic signed [SIG_W-1:0] rsp_q_ff, rsp_q_in;

   // combinational
   ucode_type           uc;
   logic                finishing, stall, adv, accept;
   logic [KD_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [LIMI_W-1:0]   lim_i;
   logic [CAP_W-1:0]    cap;
   logic signed [ACC_W-1:0] lim_acc;
   logic [KPE_W-1:0]    kpe;
   logic [INT_W-1:0]    pm;
   logic [RND_W-1:0]    inc_rnd;
   logic [INT_W-1:0]    incm;
   logic signed [ACC_W-1:0] u_sum;
   logic [ACC_W-1:0]    s_mag;
   logic [SIG_W-1:0]    v_mag;
   logic signed [SIG_W-1:0] v_out;
   logic [LIM_W:0]      lim_mag;
   logic signed [SIG_W:0] err_d, err_q;

   function automatic logic signed [ACC_W-1:0] clamp_acc(
      input logic signed [ACC_W-1:0] x,
      input logic signed [ACC_W-1:0] lim
   );
      logic signed [ACC_W-1:0] r;
      r = x;
      if (x < -lim) begin
         r = -lim;
      end else if (x > lim) begin
         r = lim;
      end
      return r;
   endfunction

   assign uc        = ucode_fetch(step_ff);
   assign finishing = (uc.seq == SEQ_FINISH) || ((uc.seq == SEQ_AXIS) && axis_ff);
   assign stall     = finishing && rsp_valid_ff && !rsp_ready;
   assign adv       = busy_ff && !stall;
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;

   assign lim_i   = LIMI_W'(lim_ff) << OUT_SHIFT;
   assign cap     = {lim_i, 1'b0};
   assign lim_acc = signed'(ACC_W'(lim_i));

   // shared multiplier operands
   always_comb begin
      unique case (uc.mul)
         MUL_KD: begin
            mul_a = KD_W'(ki_ff[axis_ff]);
            mul_b = MUL_B_W'(dt_ff);
         end
         MUL_KP: begin
            mul_a = KD_W'(kp_ff[axis_ff]);
            mul_b = MUL_B_W'(e_mag_ff[axis_ff]);
         end
         MUL_INC: begin
            mul_a = kd_ff;
            mul_b = MUL_B_W'(e_mag_ff[axis_ff]);
         end
         MUL_IDLE: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      // proportional term, Q7.24, capped at twice the limit
      kpe = prod_ff[KPE_W-1:0];
      if (kpe > KPE_W'(cap >> P_SHIFT)) begin
         pm = INT_W'(cap);
      end else begin
         pm = INT_W'(kpe << P_SHIFT);
      end

      // integral increment, rounded half away from zero on the magnitude
      inc_rnd = RND_W'(prod_ff[PROD_W-1:INC_SHIFT]) + RND_W'(prod_ff[INC_SHIFT-1]);
      if (inc_rnd > RND_W'(cap)) begin
         incm = INT_W'(cap);
      end else begin
         incm = INT_W'(inc_rnd);
      end

      u_sum = p_ff + acc_ff;

      // Q7.24 -> Q7.8 with rounding
      s_mag = s_ff[ACC_W-1] ? ACC_W'(-s_ff) : ACC_W'(s_ff);
      v_mag = s_mag[OUT_SHIFT +: SIG_W] + SIG_W'(s_mag[OUT_SHIFT-1]);
      v_out = s_ff[ACC_W-1] ? signed'(-v_mag) : signed'(v_mag);

      // limit magnitude, capped at full scale and floored at 1.0 V
      lim_mag = req_voltage_limit[SIG_W-1] ? ((LIM_W + 1)'(0) - (LIM_W + 1)'(req_voltage_limit))
                                           : (LIM_W + 1)'(req_voltage_limit);
      if (req_voltage_limit[SIG_W-1] && (lim_mag == '0)) begin
         lim_mag = SIG_MAX;     // most negative input negates to 32768, capped below
      end
      if (lim_mag > SIG_MAX) begin
         lim_mag = SIG_MAX;
      end
      if (lim_mag < LIMIT_FLOOR) begin
         lim_mag = LIMIT_FLOOR;
      end

      err_d = (SIG_W + 1)'(req_d_reference) - (SIG_W + 1)'(req_d_measured);
      err_q = (SIG_W + 1)'(req_q_reference) - (SIG_W + 1)'(req_q_measured);
   end

   // next state
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      dt_in        = dt_ff;
      lim_in       = lim_ff;
      e_mag_in     = e_mag_ff;
      e_neg_in     = e_neg_ff;
      prod_in      = prod_ff;
      kd_in        = kd_ff;
      p_in         = p_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      sat_in       = sat_ff;
      integ_in     = integ_ff;
      vd_in        = vd_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_q_in     = rsp_q_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_D_PROP_GAIN:   kp_in[0] = csr_data[KP_W-1:0];
            CSR_D_INT_GAIN:    ki_in[0] = csr_data[KI_W-1:0];
            CSR_Q_PROP_GAIN:   kp_in[1] = csr_data[KP_W-1:0];
            CSR_Q_INT_GAIN:    ki_in[1] = csr_data[KI_W-1:0];
            CSR_SAMPLE_PERIOD: dt_in    = csr_data[DT_W-1:0];
            default: ;         // drop writes beyond the register list
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         busy_in     = 1'b1;
         step_in     = STEP_KD;
         axis_in     = 1'b0;
         lim_in      = lim_mag[LIM_W-1:0];
         e_neg_in[0] = err_d[SIG_W];
         e_neg_in[1] = err_q[SIG_W];
         e_mag_in[0] = err_d[SIG_W] ? SIG_W'(-err_d) : SIG_W'(err_d);
         e_mag_in[1] = err_q[SIG_W] ? SIG_W'(-err_q) : SIG_W'(err_q);
      end

      if (adv) begin
         if (uc.mul != MUL_IDLE) begin
            prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
         end
         if (uc.ld_kd) begin
            kd_in = prod_ff[KD_W-1:0];
         end
         if (uc.ld_p) begin
            p_in = e_neg_ff[axis_ff] ? -signed'(ACC_W'(pm)) : signed'(ACC_W'(pm));
         end
         if (uc.ld_inc) begin
            inc_in = e_neg_ff[axis_ff] ? -signed'(ACC_W'(incm)) : signed'(ACC_W'(incm));
         end
         if (uc.ld_acc) begin
            acc_in = clamp_acc(ACC_W'(integ_ff[axis_ff]) + inc_ff, lim_acc);
         end
         if (uc.ld_s) begin
            s_in   = clamp_acc(u_sum, lim_acc);
            sat_in = (u_sum != clamp_acc(u_sum, lim_acc));
         end
         if (uc.wb) begin
            // back-calculate the integrator when the output saturated
            integ_in[axis_ff] = sat_ff ? INT_W'(clamp_acc(s_ff - p_ff, lim_acc))
                                       : INT_W'(acc_ff);
            if (axis_ff) begin
               rsp_d_in = vd_ff;
               rsp_q_in = v_out;
            end else begin
               vd_in = v_out;
            end
         end
         if (uc.zero_out) begin
            rsp_d_in = '0;
            rsp_q_in = '0;
         end
         if (finishing) begin
            rsp_valid_in = 1'b1;
         end

         unique case (uc.seq)
            SEQ_NEXT: step_in = step_ff + STEP_W'(1);
            SEQ_ZERO_CHK: begin
               step_in = (dt_ff == '0) ? STEP_ZERO : step_ff + STEP_W'(1);
            end
            SEQ_AXIS: begin
               if (axis_ff) begin
                  busy_in = 1'b0;
               end else begin
                  axis_in = 1'b1;
                  step_in = STEP_KD;
               end
            end
            SEQ_FINISH: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_KD;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kp_ff[0]     <= KP_RESET;
         kp_ff[1]     <= KP_RESET;
         ki_ff[0]     <= KI_RESET;
         ki_ff[1]     <= KI_RESET;
         dt_ff        <= DT_RESET;
         integ_ff[0]  <= '0;
         integ_ff[1]  <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         dt_ff        <= dt_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff   <= lim_in;
      e_mag_ff <= e_mag_in;
      e_neg_ff <= e_neg_in;
      prod_ff  <= prod_in;
      kd_ff    <= kd_in;
      p_ff     <= p_in;
      inc_ff   <= inc_in;
      acc_ff   <= acc_in;
      s_ff     <= s_in;
      sat_ff   <= sat_in;
      vd_ff    <= vd_in;
      rsp_d_ff <= rsp_d_in;
      rsp_q_ff <= rsp_q_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_d_voltage = rsp_d_ff;
   assign rsp_q_voltage = rsp_q_ff;

   // the zero step is reached only for a zero sample period
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (step_ff == STEP_ZERO)) |-> (dt_ff == '0))
      else $error("zero step entered with nonzero sample period");

   // d integrator lands inside the voltage limit after write-back
   assert property (@(posedge clock) disable iff (reset)
      (adv && uc.wb && !axis_ff) |=>
         ((ACC_W'(integ_ff[0]) <= lim_acc) && (ACC_W'(integ_ff[0]) >= -lim_acc)))
      else $error("d integrator outside limit");

   // saturated output stays inside the limit
   assert property (@(posedge clock) disable iff (reset)
      (adv && uc.ld_s) |=> ((s_ff <= lim_acc) && (s_ff >= -lim_acc)))
      else $error("saturated output outside limit");

   // a result appears only at the end of a program run
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result raised without an item in progress");

endmodule

### bench/dq_current_pi_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_current_pi_controller_tb
// Drives dq current samples through the PI controller with random gaps and
// stalls, predicts the drive voltage pairs with its own two-axis PI model
// (or a checked row's fixed pair) and compares the results in order. A short
// table of corner samples and register writes leads randomized gain phases.
// ----------------------------------------------------------------------------
module dq_current_pi_controller_tb;
   import dqpi_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 50;
   localparam int SETTLE      = 20;
   localparam int AXIS_D      = 0;
   localparam int AXIS_Q      = 1;
   localparam int CSR_SPARE_FIRST = CSR_SAMPLE_PERIOD + 1;
   localparam int CSR_SPARE_LAST  = (1 << CSR_IDX_W) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(CSR_SPARE_LAST);
   localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic signed [SIG_W-1:0] HI = 16'sh7FFF;
   localparam logic signed [SIG_W-1:0] LO = 16'sh8000;

   typedef struct packed {
      logic signed [SIG_W-1:0] d_ref;
      logic signed [SIG_W-1:0] d_meas;
      logic signed [SIG_W-1:0] q_ref;
      logic signed [SIG_W-1:0] q_meas;
      logic signed [SIG_W-1:0] vlim;
   } pi_sample_type;

   typedef struct packed {
      logic signed [SIG_W-1:0] d_volt;
      logic signed [SIG_W-1:0] q_volt;
   } drive_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum {GAIN_TYPICAL, GAIN_HIGHEST, GAIN_LOWEST, GAIN_MIXED} gain_mode_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_W-1:0]     data;
      pi_sample_type        smp;
      logic                 checked;
      drive_type            want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // fresh integrators, zero error
      '{ROW_ITEM, '0, '0, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0A00},
        1'b1, '{16'sd0, 16'sd0}},
      // limit of zero floors to 1 V, full-scale errors saturate
      '{ROW_ITEM, '0, '0, '{HI, LO, LO, HI, 16'sh0000}, 1'b1, '{16'sd256, -16'sd256}},
      '{ROW_ITEM, '0, '0, '{16'sh0100, 16'sh00C0, 16'sh00C0, 16'sh0100, 16'sh00FF},
        1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh0200, 16'sh0180, -16'sh0100, -16'sh0080, 16'sh0100},
        1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh0400, 16'sh0100, -16'sh0400, 16'sh0100, 16'sh0101},
        1'b0, '0},
      '{ROW_ITEM, '0, '0, '{-16'sh0300, 16'sh0300, 16'sh0300, -16'sh0300, -16'sh0101},
        1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh1000, 16'sh0F00, 16'sh0000, 16'sh0040, HI}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{-16'sh2000, 16'sh1000, 16'sh5555, -16'sh2AAB, LO}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0C00},
        1'b0, '0},
      // upper data bits of a 16-bit gain are dropped
      '{ROW_CSR, CSR_D_PROP_GAIN, 20'hFFFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_Q_PROP_GAIN, 20'h0FFFF, '0, 1'b0, '0},
      // most negative limit caps at full scale
      '{ROW_ITEM, '0, '0, '{HI, LO, LO, HI, LO}, 1'b1, '{16'sd32767, -16'sd32767}},
      '{ROW_ITEM, '0, '0, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, LO}, 1'b0, '0},
      '{ROW_CSR, CSR_D_INT_GAIN, 20'hFFFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_Q_INT_GAIN, 20'hFFFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_SAMPLE_PERIOD, 20'hFFFFF, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh0080, 16'sh0000, -16'sh0080, 16'sh0000, 16'sh2000},
        1'b0, '0},
      '{ROW_ITEM, '0, '0, '{-16'sh0800, 16'sh0100, 16'sh0800, -16'sh0100, 16'sh2000},
        1'b0, '0},
      '{ROW_CSR, CSR_D_PROP_GAIN, 20'h00000, '0, 1'b0, '0},
      '{ROW_CSR, CSR_Q_PROP_GAIN, 20'h00000, '0, 1'b0, '0},
      // zero period: outputs zero, integrators hold
      '{ROW_CSR, CSR_SAMPLE_PERIOD, 20'h00000, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{HI, LO, LO, HI, HI}, 1'b1, '{16'sd0, 16'sd0}},
      // write to an unused index must not land anywhere
      '{ROW_CSR, CSR_SPARE, 20'hFFFFF, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0400},
        1'b1, '{16'sd0, 16'sd0}},
      '{ROW_CSR, CSR_SAMPLE_PERIOD, CSR_W'(DT_RESET), '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{16'sh0200, 16'sh0100, 16'sh0100, 16'sh0200, 16'sh0800},
        1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [SIG_W-1:0] req_d_reference = '0;
   logic signed [SIG_W-1:0] req_d_measured = '0;
   logic signed [SIG_W-1:0] req_q_reference = '0;
   logic signed [SIG_W-1:0] req_q_measured = '0;
   logic signed [SIG_W-1:0] req_voltage_limit = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [SIG_W-1:0] rsp_d_voltage;
   logic signed [SIG_W-1:0] rsp_q_voltage;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_data = '0;

   // controller model state
   longint unsigned kp_gain [2];
   longint unsigned ki_gain [2];
   longint unsigned period_model;
   longint          integrator_model [2];

   drive_type expected_drives [$];
   drive_type oldest_drive;
   int     failures = 0;
   int     cycle_count = 0;
   int     stall_left = 0;
   bit     quiet = 1'b0;

   dq_current_pi_controller i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_d_reference   (req_d_reference),
      .req_d_measured    (req_d_measured),
      .req_q_reference   (req_q_reference),
      .req_q_measured    (req_q_measured),
      .req_voltage_limit (req_voltage_limit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_d_voltage     (rsp_d_voltage),
      .rsp_q_voltage     (rsp_q_voltage),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   task automatic report_failure(input string msg);
      $display("ERROR: %s (at %0t)", msg, $time);
      failures++;
   endtask

   // Round to nearest on the magnitude, ties away from zero; negative shift scales up.
   function automatic longint unsigned round_scale(longint unsigned mag, int sh,
                                                   longint unsigned cap);
      longint unsigned r;
      if (sh > 0)
         r = (mag >> sh) + ((mag >> (sh - 1)) & 64'd1);
      else if (sh < 0)
         r = (mag > (cap >> -sh)) ? cap : (mag << -sh);
      else
         r = mag;
      return (r > cap) ? cap : r;
   endfunction

   function automatic longint clamp_sym(longint x, longint lim);
      if (x < -lim) return -lim;
      if (x > lim) return lim;
      return x;
   endfunction

   function automatic logic signed [SIG_W-1:0] axis_drive(int axis, longint err,
                                                          longint lim_i);
      logic            neg;
      longint unsigned e, cap, kd, prod, inc_mag, p_mag, s_mag;
      longint          inc, p, acc, u, s;
      neg = err < 0;
      e = neg ? -err : err;
      cap = lim_i * 2;
      kd = ki_gain[axis] * period_model;
      prod = (e != 0 && kd > U64_MAX / e) ? U64_MAX : kd * e;
      inc_mag = round_scale(prod, INC_SHIFT, cap);
      p_mag = round_scale(kp_gain[axis] * e, -P_SHIFT, cap);
      inc = neg ? -longint'(inc_mag) : longint'(inc_mag);
      p = neg ? -longint'(p_mag) : longint'(p_mag);
      acc = clamp_sym(integrator_model[axis] + inc, lim_i);
      u = p + acc;
      s = clamp_sym(u, lim_i);
      // back-calculate the integrator when the output saturates
      if (u != s)
         acc = clamp_sym(s - p, lim_i);
      integrator_model[axis] = acc;
      s_mag = round_scale((s < 0) ? -s : s, OUT_SHIFT, U64_MAX);
      return SIG_W'((s < 0) ? -longint'(s_mag) : longint'(s_mag));
   endfunction

   function automatic drive_type predict_drive(pi_sample_type smp);
      drive_type res;
      longint lim;
      if (period_model == 0)
         return '0;
      lim = longint'(smp.vlim);
      if (lim < 0) lim = -lim;
      if (lim > longint'(SIG_MAX)) lim = longint'(SIG_MAX);
      if (lim < longint'(LIMIT_FLOOR)) lim = longint'(LIMIT_FLOOR);
      res.d_volt = axis_drive(AXIS_D, longint'(smp.d_ref) - longint'(smp.d_meas),
                              lim << OUT_SHIFT);
      res.q_volt = axis_drive(AXIS_Q, longint'(smp.q_ref) - longint'(smp.q_meas),
                              lim << OUT_SHIFT);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SIG_W-1:0] corner_value();
      unique case ($urandom_range(0, 5))
         0: return HI;
         1: return LO;
         2: return '0;
         3: return 16'sd1;
         4: return -16'sd1;
         default: return SIG_W'($urandom);
      endcase
   endfunction

   // Mostly a loop that tracks its reference, the rest full-range noise and corners.
   function automatic pi_sample_type random_sample();
      pi_sample_type smp;
      int            mix;
      mix = $urandom_range(0, 99);
      if (mix < 60) begin
         smp.d_ref  = SIG_W'(int'($urandom_range(0, 16384)) - 8192);
         smp.d_meas = SIG_W'(int'(smp.d_ref) + int'($urandom_range(0, 512)) - 256);
         smp.q_ref  = SIG_W'(int'($urandom_range(0, 16384)) - 8192);
         smp.q_meas = SIG_W'(int'(smp.q_ref) + int'($urandom_range(0, 512)) - 256);
         smp.vlim   = SIG_W'($urandom_range(0, 6144));
         if ($urandom_range(0, 3) == 0)
            smp.vlim = -smp.vlim;
      end else if (mix < 85) begin
         smp.d_ref  = SIG_W'($urandom);
         smp.d_meas = SIG_W'($urandom);
         smp.q_ref  = SIG_W'($urandom);
         smp.q_meas = SIG_W'($urandom);
         smp.vlim   = SIG_W'($urandom);
      end else begin
         smp.d_ref  = corner_value();
         smp.d_meas = corner_value();
         smp.q_ref  = corner_value();
         smp.q_meas = corner_value();
         smp.vlim   = corner_value();
      end
      return smp;
   endfunction

   function automatic logic [CSR_W-1:0] pick_csr_value(logic [CSR_IDX_W-1:0] idx,
                                                       gain_mode_type mode);
      unique case (mode)
         GAIN_HIGHEST: return '1;
         GAIN_LOWEST:  return (idx == CSR_SAMPLE_PERIOD) ? CSR_W'(1) : '0;
         GAIN_TYPICAL: begin
            if (idx == CSR_D_PROP_GAIN || idx == CSR_Q_PROP_GAIN)
               return CSR_W'($urandom_range(0, 16384));
            if (idx == CSR_SAMPLE_PERIOD)
               return CSR_W'($urandom_range(400, 20000));
            return CSR_W'($urandom_range(0, 1 << 18));
         end
         default: begin
            unique case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return pick_csr_value(idx, GAIN_TYPICAL);
               default: return CSR_W'($urandom);
            endcase
         end
      endcase
   endfunction

   // Hold the write enable high; the next transfer drops it.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      unique case (idx)
         CSR_D_PROP_GAIN:   kp_gain[AXIS_D] = data[KP_W-1:0];
         CSR_D_INT_GAIN:    ki_gain[AXIS_D] = data[KI_W-1:0];
         CSR_Q_PROP_GAIN:   kp_gain[AXIS_Q] = data[KP_W-1:0];
         CSR_Q_INT_GAIN:    ki_gain[AXIS_Q] = data[KI_W-1:0];
         CSR_SAMPLE_PERIOD: period_model = data[DT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(input pi_sample_type smp, input logic checked,
                              input drive_type typed);
      int        gap;
      drive_type forecast;
      gap = pick_gap();
      csr_write_en <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_d_reference <= smp.d_ref;
      req_d_measured <= smp.d_meas;
      req_q_reference <= smp.q_ref;
      req_q_measured <= smp.q_meas;
      req_voltage_limit <= smp.vlim;
      do @(posedge clock); while (!req_ready);
      forecast = predict_drive(smp);
      expected_drives.push_back(checked ? typed : forecast);
   endtask

   task automatic wait_idle();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_drives.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_drives.size() == 0) begin
               report_failure($sformatf("unexpected transfer d %0d q %0d",
                                        rsp_d_voltage, rsp_q_voltage));
            end else begin
               oldest_drive = expected_drives.pop_front();
               if (rsp_d_voltage !== oldest_drive.d_volt)
                  report_failure($sformatf("d_voltage got %0d expected %0d",
                                           rsp_d_voltage, oldest_drive.d_volt));
               if (rsp_q_voltage !== oldest_drive.q_volt)
                  report_failure($sformatf("q_voltage got %0d expected %0d",
                                           rsp_q_voltage, oldest_drive.q_volt));
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int            row, phase, r, n;
      gain_mode_type mode;
      kp_gain = '{KP_RESET, KP_RESET};
      ki_gain = '{KI_RESET, KI_RESET};
      period_model = DT_RESET;
      integrator_model = '{0, 0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].kind == ROW_CSR) begin
            wait_idle();
            write_csr(DIRECTED[row].index, DIRECTED[row].data);
         end else begin
            send_sample(DIRECTED[row].smp, DIRECTED[row].checked, DIRECTED[row].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         mode = gain_mode_type'(phase % 4);
         quiet = (phase % 5 == 4);
         for (r = CSR_D_PROP_GAIN; r <= CSR_SAMPLE_PERIOD; r++)
            if (mode != GAIN_MIXED || $urandom_range(0, 1) == 1)
               write_csr(CSR_IDX_W'(r), pick_csr_value(CSR_IDX_W'(r), mode));
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                      CSR_W'($urandom));
         for (n = 0; n < PHASE_ITEMS; n++)
            send_sample(random_sample(), 1'b0, '0);
      end

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
